[sv/rrs_pkg.sv]
`timescale 1ns / 1ps
package rrs_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W  = 32;
  localparam int DIM_W   = 7;
  localparam int DECAY_W = 17;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Depths of the command and result queues
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // Decay of 1.0 in unsigned Q1.16
  localparam logic [DECAY_W-1:0] DECAY_ONE = 17'h10000;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_LEN_ERR = 1'b1;

  // Register select, taken from the word address
  typedef enum logic {
    REG_DECAY = 1'b0,
    REG_DIM   = 1'b1
  } reg_sel_t;

  // Command from the front end to the back end
  typedef enum logic {
    CMD_RUN   = 1'b0,
    CMD_ERROR = 1'b1
  } cmd_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic done;
  } back_stat_t;

  // One result transaction
  typedef struct packed {
    logic [DATA_W-1:0] elem;
    logic              status;
    logic              last;
  } result_t;

endpackage

[sv/rrs_ram.sv]
`timescale 1ns / 1ps
module rrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rrs_fifo.sv]
`timescale 1ns / 1ps
module rrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store an entry on push
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(do_push) - CNTW'(do_pop);
    end
  end

endmodule

[sv/rrs_front.sv]
`timescale 1ns / 1ps
module rrs_front import rrs_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_last,
  input  logic [DIM_W-1:0]           active_dim,
  output logic                       buf_we,
  output logic [$clog2(MAX_DIM)-1:0] buf_addr,
  output logic                       cmd_push,
  output cmd_t                       cmd_data,
  input  logic                       cmd_full,
  input  back_stat_t                 back_stat
);

  localparam int AW = $clog2(MAX_DIM);
  localparam int CW = $clog2(MAX_DIM + 2);

  logic [CW-1:0] load_count;
  logic [CW-1:0] count_inc;
  logic          locked;
  logic          accept;
  logic          len_ok;

  // Buffers stay locked while the back end reads them
  assign full   = locked || cmd_full || back_stat.clearing;
  assign accept = push && !full;

  // Count saturates one past the largest dimension
  assign count_inc = (load_count <= CW'(MAX_DIM)) ? load_count + 1'b1 : load_count;
  assign len_ok    = (active_dim == DIM_W'(count_inc)) &&
                     (active_dim <= DIM_W'(MAX_DIM));

  // Store elements that fit, drop the rest
  assign buf_we   = accept && (load_count < CW'(MAX_DIM));
  assign buf_addr = load_count[AW-1:0];

  // Classify the burst on its closing transaction
  assign cmd_push = accept && in_last;
  assign cmd_data = len_ok ? CMD_RUN : CMD_ERROR;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      locked     <= 1'b0;
    end else begin
      if (accept) begin
        load_count <= in_last ? '0 : count_inc;
      end
      if (cmd_push && len_ok) begin
        locked <= 1'b1;
      end else if (back_stat.done) begin
        locked <= 1'b0;
      end
    end
  end

endmodule

[sv/rrs_back.sv]
`timescale 1ns / 1ps
module rrs_back import rrs_pkg::*; #(
  parameter int MAX_DIM    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_empty,
  input  cmd_t                       cmd_data,
  output logic                       cmd_pop,
  input  logic [DIM_W-1:0]           active_dim,
  input  logic [DECAY_W-1:0]         decay_factor,
  output back_stat_t                 stat,
  output logic [$clog2(MAX_DIM)-1:0] row_raddr,
  output logic [$clog2(MAX_DIM)-1:0] col_raddr,
  input  logic [DATA_W-1:0]          q_rdata,
  input  logic [DATA_W-1:0]          k_rdata,
  input  logic [DATA_W-1:0]          v_rdata,
  input  logic                       pop,
  output logic                       empty,
  output logic [DATA_W-1:0]          out_elem,
  output logic                       status,
  output logic                       out_last
);

  localparam int AW       = $clog2(MAX_DIM);
  localparam int CELLS    = MAX_DIM * MAX_DIM;
  localparam int MW       = $clog2(CELLS);
  localparam int RW       = $clog2(RES_DEPTH + 1);
  localparam int SAT_W    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int DEC_W    = DATA_W + DECAY_W + 1;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int UPD_W    = PROD_W + 2;
  localparam int ACC_W    = PROD_W + AW + 1;
  localparam int SAT_IN_W = ACC_W - 16;

  localparam logic signed [DATA_W-1:0] SAT_HI =
    DATA_W'((64'd1 << (SAT_W - 1)) - 64'd1);
  localparam logic signed [DATA_W-1:0] SAT_LO   = ~SAT_HI;
  localparam logic signed [UPD_W-1:0]  RND_UPD  = UPD_W'(32'sh8000);
  localparam logic signed [ACC_W-1:0]  RND_ACC  = ACC_W'(32'sh8000);
  localparam logic [MW-1:0]            CLR_LAST = MW'(CELLS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Clamp to the signed range of the data word
  function automatic logic [DATA_W-1:0] sat_fn(input logic signed [SAT_IN_W-1:0] x);
    logic [DATA_W-1:0] r;
    priority if (x > SAT_IN_W'(SAT_HI)) begin
      r = SAT_HI;
    end else if (x < SAT_IN_W'(SAT_LO)) begin
      r = SAT_LO;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  state_t          state;
  logic [MW-1:0]   clr_addr;
  logic [AW-1:0]   idx_a;
  logic [AW-1:0]   idx_b;
  logic [RW-1:0]   reserved;
  logic [RW-1:0]   reserved_next;

  logic [AW-1:0]      dim_m1;
  logic               last_a;
  logic               last_b;
  logic               has_credit;
  logic               issue;
  logic               run_start;
  logic               err_emit;
  logic               reserve;
  logic               res_pop;
  logic               pipe_busy;
  logic [DECAY_W-1:0] decay_eff;

  // Matrix memory ports
  logic              mat_we;
  logic [MW-1:0]     mat_waddr;
  logic [DATA_W-1:0] mat_wdata;
  logic [MW-1:0]     mat_raddr;
  logic [DATA_W-1:0] mat_rdata;

  // Pipeline stages
  logic                     p1_vld, p1_first, p1_lasta, p1_lastb;
  logic [MW-1:0]            p1_addr;
  logic                     p2_vld, p2_first, p2_lasta, p2_lastb;
  logic [MW-1:0]            p2_addr;
  logic signed [DEC_W-1:0]  p2_dec;
  logic signed [PROD_W-1:0] p2_kv;
  logic signed [DATA_W-1:0] p2_q;
  logic                     p3_vld, p3_first, p3_lasta, p3_lastb;
  logic [MW-1:0]            p3_addr;
  logic signed [DATA_W-1:0] p3_s;
  logic signed [DATA_W-1:0] p3_q;
  logic                     p4_vld, p4_first, p4_lasta, p4_lastb;
  logic signed [PROD_W-1:0] p4_prod;
  logic                     p5_vld, p5_last;
  logic signed [ACC_W-1:0]  acc_sum;

  logic signed [UPD_W-1:0]  upd_sum;
  logic signed [ACC_W-1:0]  out_round;
  result_t                  res_wdata;
  result_t                  res_rdata;
  logic                     res_push;

  // Sequencer decode
  assign dim_m1     = AW'(active_dim - DIM_W'(1));
  assign last_a     = (idx_a == dim_m1);
  assign last_b     = (idx_b == dim_m1);
  assign has_credit = (reserved < RW'(RES_DEPTH));
  assign issue      = (state == ST_RUN) && ((idx_a != '0) || has_credit);
  assign run_start  = (state == ST_IDLE) && !cmd_empty && (cmd_data == CMD_RUN);
  assign err_emit   = (state == ST_IDLE) && !cmd_empty && (cmd_data == CMD_ERROR) &&
                      has_credit;
  assign cmd_pop    = run_start || err_emit;
  assign reserve    = err_emit || (issue && (idx_a == '0));
  assign res_pop    = pop && !empty;
  assign pipe_busy  = p1_vld || p2_vld || p3_vld || p4_vld || p5_vld;

  assign reserved_next = reserved + RW'(reserve) - RW'(res_pop);

  assign stat.clearing = (state == ST_CLEAR);
  assign stat.done     = (state == ST_DRAIN) && !pipe_busy;

  assign decay_eff = (decay_factor > DECAY_ONE) ? DECAY_ONE : decay_factor;

  // Column-major walk: row index inner, column index outer
  assign row_raddr = idx_a;
  assign col_raddr = idx_b;
  assign mat_raddr = MW'(idx_a) * MW'(MAX_DIM) + MW'(idx_b);

  // Write back updated cells, or zeros during the clearing pass
  assign mat_we    = (state == ST_CLEAR) || p3_vld;
  assign mat_waddr = (state == ST_CLEAR) ? clr_addr : p3_addr;
  assign mat_wdata = (state == ST_CLEAR) ? '0 : p3_s;

  rrs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELLS)
  ) u_matrix (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  // Sequencer state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      idx_a    <= '0;
      idx_b    <= '0;
      reserved <= '0;
    end else begin
      reserved <= reserved_next;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (run_start) begin
            idx_a <= '0;
            idx_b <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (last_a) begin
              idx_a <= '0;
              if (last_b) begin
                state <= ST_DRAIN;
              end else begin
                idx_b <= idx_b + 1'b1;
              end
            end else begin
              idx_a <= idx_a + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Round the cell update and the output sum to Q16.16
  assign upd_sum   = UPD_W'(p2_dec) + UPD_W'(p2_kv) + RND_UPD;
  assign out_round = acc_sum + RND_ACC;

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      p5_vld <= 1'b0;
    end else begin
      p1_vld <= issue;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
      p5_vld <= p4_vld && p4_lasta;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    // issue: memories read this cycle
    p1_addr  <= mat_raddr;
    p1_first <= (idx_a == '0);
    p1_lasta <= last_a;
    p1_lastb <= last_b;
    // form decay*S and k*v
    p2_addr  <= p1_addr;
    p2_first <= p1_first;
    p2_lasta <= p1_lasta;
    p2_lastb <= p1_lastb;
    p2_dec   <= $signed(mat_rdata) * $signed({1'b0, decay_eff});
    p2_kv    <= $signed(k_rdata) * $signed(v_rdata);
    p2_q     <= $signed(q_rdata);
    // round and clamp the new cell
    p3_addr  <= p2_addr;
    p3_first <= p2_first;
    p3_lasta <= p2_lasta;
    p3_lastb <= p2_lastb;
    p3_s     <= sat_fn(SAT_IN_W'($signed(upd_sum[UPD_W-1:16])));
    p3_q     <= p2_q;
    // weight the new cell by the query element
    p4_first <= p3_first;
    p4_lasta <= p3_lasta;
    p4_lastb <= p3_lastb;
    p4_prod  <= p3_q * p3_s;
    // accumulate the column exactly
    if (p4_vld) begin
      acc_sum <= p4_first ? ACC_W'(p4_prod) : acc_sum + ACC_W'(p4_prod);
    end
    p5_last <= p4_lastb;
  end

  // Push a finished column or a length error
  assign res_push = p5_vld || err_emit;

  always_comb begin
    if (err_emit) begin
      res_wdata.elem   = '0;
      res_wdata.status = STATUS_LEN_ERR;
      res_wdata.last   = 1'b1;
    end else begin
      res_wdata.elem   = sat_fn($signed(out_round[ACC_W-1:16]));
      res_wdata.status = STATUS_OK;
      res_wdata.last   = p5_last;
    end
  end

  rrs_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign out_elem = res_rdata.elem;
  assign status   = res_rdata.status;
  assign out_last = res_rdata.last;

endmodule

[sv/retention_recurrent_step_unit.sv]
`timescale 1ns / 1ps
// Recurrent retention step: S = decay*S + k*v', then o = q'*S, Q16.16 saturating.
// Input queue side: one q/k/v element per transaction (push, full); in_last
// closes the burst of one time step. Elements load at one per cycle.
// Result queue side: (empty, pop); a good burst yields active_dim results, the
// last with out_last set; a burst of the wrong length yields one result with
// status set and leaves the matrix unchanged.
// Processing: after the closing element the back end walks the matrix column by
// column, one multiply-accumulate per cycle through the single read port of the
// matrix memory, except that a new column waits while no result queue entry is
// free. full stays high while the back end works on a burst, since the element
// buffers are in use.
// Reset: a clearing pass writes zero to all MAX_DIM^2 matrix cells, one per
// cycle; full stays high until it finishes.
// Configuration writes are taken at any time through the register port.
// Receiver stall: results wait in a 4-entry queue; the back end holds off
// starting a new column while no queue entry is free, so nothing is dropped.
module retention_recurrent_step_unit import rrs_pkg::*; #(
  parameter int MAX_DIM    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  // input queue
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] q_elem,
  input  logic [DATA_W-1:0] k_elem,
  input  logic [DATA_W-1:0] v_elem,
  input  logic              in_last,
  // result queue
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] out_elem,
  output logic              status,
  output logic              out_last,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(MAX_DIM);

  logic [DECAY_W-1:0] decay_factor;
  logic [DIM_W-1:0]   active_dim;
  reg_sel_t           reg_sel;
  logic               cfg_wr;

  logic               buf_we;
  logic [AW-1:0]      buf_addr;
  logic [AW-1:0]      row_raddr;
  logic [AW-1:0]      col_raddr;
  logic [DATA_W-1:0]  q_rdata;
  logic [DATA_W-1:0]  k_rdata;
  logic [DATA_W-1:0]  v_rdata;

  logic               cmd_push;
  cmd_t               cmd_wdata;
  logic               cmd_full;
  logic               cmd_pop;
  logic               cmd_empty;
  logic [0:0]         cmd_rbits;
  back_stat_t         back_stat;

  // Register port: no wait states
  assign pready  = 1'b1;
  assign reg_sel = reg_sel_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor <= DECAY_ONE;
      active_dim   <= DIM_W'(MAX_DIM);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DECAY: decay_factor <= pwdata[DECAY_W-1:0];
        REG_DIM:   active_dim   <= pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DECAY: prdata = APB_DW'(decay_factor);
      REG_DIM:   prdata = APB_DW'(active_dim);
    endcase
  end

  // Front end: load and classify bursts
  rrs_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_last    (in_last),
    .active_dim (active_dim),
    .buf_we     (buf_we),
    .buf_addr   (buf_addr),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_wdata),
    .cmd_full   (cmd_full),
    .back_stat  (back_stat)
  );

  // Element buffers
  rrs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DIM)
  ) u_q_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_addr),
    .wdata (q_elem),
    .raddr (row_raddr),
    .rdata (q_rdata)
  );

  rrs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DIM)
  ) u_k_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_addr),
    .wdata (k_elem),
    .raddr (row_raddr),
    .rdata (k_rdata)
  );

  rrs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DIM)
  ) u_v_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_addr),
    .wdata (v_elem),
    .raddr (col_raddr),
    .rdata (v_rdata)
  );

  // Command queue between front and back end
  rrs_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rbits),
    .empty (cmd_empty)
  );

  // Back end: matrix update, output sums, result queue
  rrs_back #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_empty    (cmd_empty),
    .cmd_data     (cmd_t'(cmd_rbits)),
    .cmd_pop      (cmd_pop),
    .active_dim   (active_dim),
    .decay_factor (decay_factor),
    .stat         (back_stat),
    .row_raddr    (row_raddr),
    .col_raddr    (col_raddr),
    .q_rdata      (q_rdata),
    .k_rdata      (k_rdata),
    .v_rdata      (v_rdata),
    .pop          (pop),
    .empty        (empty),
    .out_elem     (out_elem),
    .status       (status),
    .out_last     (out_last)
  );

endmodule

[verif/tb_retention_recurrent_step_unit.sv]
`timescale 1ns / 1ps
module tb_retention_recurrent_step_unit import rrs_pkg::*;;

  localparam int MAX_DIM = 64;

  typedef struct packed {
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] v;
    logic              last;
  } elem_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [DATA_W-1:0] q_elem = '0;
  logic [DATA_W-1:0] k_elem = '0;
  logic [DATA_W-1:0] v_elem = '0;
  logic              in_last = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [DATA_W-1:0] out_elem;
  logic              status;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  retention_recurrent_step_unit DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .q_elem(q_elem), .k_elem(k_elem), .v_elem(v_elem), .in_last(in_last),
    .empty(empty), .pop(pop),
    .out_elem(out_elem), .status(status), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Mirror of the block state
  logic signed [DATA_W-1:0] ret_mat [MAX_DIM][MAX_DIM];
  logic signed [DATA_W-1:0] q_buf [MAX_DIM];
  logic signed [DATA_W-1:0] k_buf [MAX_DIM];
  logic signed [DATA_W-1:0] v_buf [MAX_DIM];
  int                       load_cnt = 0;
  logic [DECAY_W-1:0]       cfg_decay = DECAY_ONE;
  logic [DIM_W-1:0]         cfg_dim = 7'd64;

  elem_t   elem_queue [$];
  result_t expected_out [$];
  int      mismatch_count = 0;
  int      idle_max = 17;
  int      feed_gap = 0;
  int      pop_gap = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [DATA_W-1:0] sat_q16(input longint x);
    longint hi;
    longint lo;
    hi = 64'sd2147483647;
    lo = -hi - 1;
    if (x > hi) return 32'h7FFF_FFFF;
    if (x < lo) return 32'h8000_0000;
    return x[DATA_W-1:0];
  endfunction

  // Take one element; on the closing element update the matrix and queue the outputs
  task automatic absorb_element(input elem_t e);
    int      n;
    longint  dcy;
    longint  acc;
    longint  prod;
    longint  high_sum;
    logic [63:0] low_sum;
    result_t r;
    if (load_cnt < MAX_DIM) begin
      q_buf[load_cnt] = e.q;
      k_buf[load_cnt] = e.k;
      v_buf[load_cnt] = e.v;
    end
    if (load_cnt <= MAX_DIM) load_cnt++;
    if (!e.last) return;
    n = load_cnt;
    load_cnt = 0;
    if (cfg_dim == 0 || cfg_dim > MAX_DIM || n != int'(cfg_dim)) begin
      r.elem = '0;
      r.status = STATUS_LEN_ERR;
      r.last = 1'b1;
      expected_out.push_back(r);
      return;
    end
    dcy = (cfg_decay > DECAY_ONE) ? longint'(DECAY_ONE) : longint'(cfg_decay);
    for (int a = 0; a < cfg_dim; a++) begin
      for (int b = 0; b < cfg_dim; b++) begin
        acc = dcy * longint'(ret_mat[a][b]) + longint'(k_buf[a]) * longint'(v_buf[b]);
        ret_mat[a][b] = sat_q16((acc + 32768) >>> 16);
      end
    end
    // Project the query onto each column, rounding once per sum
    for (int b = 0; b < cfg_dim; b++) begin
      high_sum = 0;
      low_sum = '0;
      for (int a = 0; a < cfg_dim; a++) begin
        prod = longint'(q_buf[a]) * longint'(ret_mat[a][b]);
        high_sum += prod >>> 16;
        low_sum += prod & 64'hFFFF;
      end
      r.elem = sat_q16(high_sum + longint'((low_sum + 64'h8000) >> 16));
      r.status = STATUS_OK;
      r.last = (b == cfg_dim - 1);
      expected_out.push_back(r);
    end
  endtask

  // Feed elements from the pending queue, with a random gap after each transaction
  always @(posedge clk) begin : feed
    int    g;
    elem_t nxt;
    if (rst) begin
      push <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (push && !full) begin
        nxt = {q_elem, k_elem, v_elem, in_last};
        absorb_element(nxt);
        g = $urandom_range(0, idle_max);
      end else begin
        g = feed_gap;
      end
      if (push && full) begin
        feed_gap <= g;
      end else if (g > 0) begin
        push <= 1'b0;
        feed_gap <= g - 1;
      end else if (elem_queue.size() > 0) begin
        nxt = elem_queue.pop_front();
        q_elem <= nxt.q;
        k_elem <= nxt.k;
        v_elem <= nxt.v;
        in_last <= nxt.last;
        push <= 1'b1;
        feed_gap <= 0;
      end else begin
        push <= 1'b0;
        feed_gap <= 0;
      end
    end
  end

  // Accept results with random stalls and compare against the oldest expectation
  always @(posedge clk) begin : drain_results
    int      g;
    result_t want;
    if (rst) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", out_elem));
        end else begin
          want = expected_out.pop_front();
          if (out_elem !== want.elem)
            report_mismatch($sformatf("out_elem %h, want %h", out_elem, want.elem));
          if (status !== want.status)
            report_mismatch($sformatf("status %b, want %b", status, want.status));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
        end
        g = $urandom_range(0, idle_max);
      end else begin
        g = pop_gap;
      end
      if (g > 0) begin
        pop <= 1'b0;
        pop_gap <= g - 1;
      end else begin
        pop <= 1'b1;
        pop_gap <= 0;
      end
    end
  end

  task automatic apb_access(input reg_sel_t sel, input logic wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_AW'({sel, 2'b00});
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input reg_sel_t sel, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] got;
    apb_access(sel, 1'b0, '0, got);
    if (got !== want)
      report_mismatch($sformatf("register %s reads %h, want %h", sel.name(), got, want));
  endtask

  task automatic set_register(input reg_sel_t sel, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] unused;
    apb_access(sel, 1'b1, value, unused);
    if (sel == REG_DECAY) begin
      cfg_decay = value[DECAY_W-1:0];
      check_register(sel, APB_DW'(cfg_decay));
    end else begin
      cfg_dim = value[DIM_W-1:0];
      check_register(sel, APB_DW'(cfg_dim));
    end
  endtask

  // Wait until every queued element is taken and every expected result has come
  task automatic drain(input int settle);
    while (elem_queue.size() > 0 || push || expected_out.size() > 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom;
      default: return DATA_W'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
    endcase
  endfunction

  task automatic queue_burst(input int len);
    elem_t e;
    for (int i = 0; i < len; i++) begin
      e.q = pick_word();
      e.k = pick_word();
      e.v = pick_word();
      e.last = (i == len - 1);
      elem_queue.push_back(e);
    end
  endtask

  task automatic queue_const_burst(input int len, input logic [DATA_W-1:0] w);
    elem_t e;
    for (int i = 0; i < len; i++) begin
      e = {w, w, w, i == len - 1};
      elem_queue.push_back(e);
    end
  endtask

  initial begin : stimulus
    int rand_items;
    int phase;
    int dim;
    int bursts;
    int len;
    for (int a = 0; a < MAX_DIM; a++)
      for (int b = 0; b < MAX_DIM; b++)
        ret_mat[a][b] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset values, then wrong-length bursts at the full dimension
    check_register(REG_DECAY, APB_DW'(DECAY_ONE));
    check_register(REG_DIM, APB_DW'(7'd64));
    queue_burst(1);
    queue_burst(3);
    drain(16);

    // Saturating extremes at a small dimension, then zero and over-range decay
    set_register(REG_DIM, 2);
    queue_const_burst(2, 32'h7FFF_FFFF);
    queue_const_burst(2, 32'h8000_0000);
    queue_burst(2);
    drain(16);
    set_register(REG_DECAY, 0);
    queue_burst(2);
    drain(16);
    set_register(REG_DECAY, 32'h1FFFF);
    queue_burst(2);
    drain(16);

    // Unusable dimensions, then the smallest one
    set_register(REG_DIM, 0);
    queue_burst(1);
    drain(16);
    set_register(REG_DIM, 127);
    queue_burst(2);
    drain(16);
    set_register(REG_DIM, 1);
    queue_burst(1);
    queue_burst(2);
    drain(16);

    // Random phases, each with its own settings and idle pattern
    rand_items = 0;
    phase = 0;
    while (rand_items < 130) begin
      case ($urandom_range(0, 4))
        0: set_register(REG_DECAY, 0);
        1: set_register(REG_DECAY, APB_DW'(DECAY_ONE));
        2: set_register(REG_DECAY, $urandom_range(65537, 131071));
        default: set_register(REG_DECAY, $urandom_range(0, 65536));
      endcase
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      if (phase == 2) begin
        // one full-size step, slow in the back end
        dim = 64;
        set_register(REG_DIM, dim);
        queue_burst(dim);
        rand_items += dim;
      end else if (phase == 5) begin
        // overlong burst drops its tail and ends in error
        dim = $urandom_range(1, 4);
        set_register(REG_DIM, dim);
        len = $urandom_range(65, 66);
        queue_burst(len);
        queue_burst(dim);
        rand_items += len + dim;
      end else begin
        case ($urandom_range(0, 9))
          0: dim = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
          1, 2: dim = 1;
          default: dim = $urandom_range(2, 6);
        endcase
        set_register(REG_DIM, dim);
        bursts = $urandom_range(1, 4);
        for (int i = 0; i < bursts; i++) begin
          if (dim == 0 || dim > MAX_DIM) begin
            len = $urandom_range(1, 3);
          end else if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, dim + 2);
            if (len == dim) len = dim + 1;
          end else begin
            len = dim;
          end
          queue_burst(len);
          rand_items += len;
        end
      end
      drain(16);
      phase++;
    end

    drain(100);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[retention_recurrent_step_unit.f]
sv/rrs_pkg.sv
sv/rrs_ram.sv
sv/rrs_fifo.sv
sv/rrs_front.sv
sv/rrs_back.sv
sv/retention_recurrent_step_unit.sv
verif/tb_retention_recurrent_step_unit.sv
